@@ hdl/trapezoid_segment_planner_defines.svh @@
// -----------------------------------------------------------------------------
// trapezoid_segment_planner_defines: assertion macros
// Wrap concurrent assertions so that a build can drop them with ASSERT_OFF.
// -----------------------------------------------------------------------------
`ifndef TRAPEZOID_SEGMENT_PLANNER_DEFINES_SVH
`define TRAPEZOID_SEGMENT_PLANNER_DEFINES_SVH

`ifndef ASSERT_OFF
// check under reset qualification
`define TSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every clock edge, reset included
`define TSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSP_ASSERT(lbl, prop, msg)
`define TSP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hdl/tsp_pkg.sv @@
// -----------------------------------------------------------------------------
// tsp_pkg: shared types and constants of the trapezoid segment planner
// Widths, reset values, sequencer states and arithmetic unit controls.
// -----------------------------------------------------------------------------
package tsp_pkg;

  localparam int AXES_DEF  = 4;
  localparam int FRAC_BITS = 16;

  localparam int PW  = 100;  // product / numerator width
  localparam int BW  = 50;   // multiplier / divisor width
  localparam int RW  = 53;   // partial remainder width
  localparam int CW  = 7;    // step counter width
  localparam int DIV_STEPS  = PW;
  localparam int SQRT_STEPS = PW / 2;

  localparam logic [46:0] START_RST = 47'd327680;
  localparam logic [46:0] ACCEL_RST = 47'd6553600;
  localparam logic [46:0] WANT_RST  = 47'(64'd1000000 << FRAC_BITS);

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_ACCEL = 1'b1;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } op_t;

  typedef enum logic [1:0] {
    PLAN_ECHO,
    PLAN_CONST,
    PLAN_LIMIT,
    PLAN_FULL
  } plan_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUMSQ,
    ST_SUMSQ_RUN,
    ST_ROOT,
    ST_ROOT_RUN,
    ST_LEN,
    ST_LEN_RUN,
    ST_RAMP,
    ST_RAMP_RUN,
    ST_OFFMUL,
    ST_OFFMUL_RUN,
    ST_OFFDIV,
    ST_OFFDIV_RUN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic go;
    op_t  op;
    logic clr;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

endpackage

@@ hdl/tsp_alu.sv @@
// -----------------------------------------------------------------------------
// tsp_alu: shared iterative arithmetic unit
// Shift-add multiply, restoring divide and digit-by-digit square root.
// -----------------------------------------------------------------------------
module tsp_alu (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tsp_pkg::alu_req_t         req,
  input  logic [tsp_pkg::PW-1:0]    opa,
  input  logic [tsp_pkg::BW-1:0]    opb,
  output tsp_pkg::alu_stat_t        stat,
  output logic [tsp_pkg::PW-1:0]    res
);

  localparam int PW = tsp_pkg::PW;
  localparam int BW = tsp_pkg::BW;
  localparam int RW = tsp_pkg::RW;
  localparam int CW = tsp_pkg::CW;

  tsp_pkg::op_t  op_r, op_nxt;
  logic [PW-1:0] acc_r, acc_nxt;
  logic [PW-1:0] num_r, num_nxt;
  logic [BW-1:0] b_r, b_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [RW-1:0] sh, sub, dif;
  logic          ge;

  always_comb begin
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    num_nxt  = num_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = '0;
    sub      = '0;
    dif      = '0;
    ge       = 1'b0;
    if (req.go) begin
      op_nxt   = req.op;
      num_nxt  = opa;
      b_nxt    = opb;
      rem_nxt  = '0;
      busy_nxt = 1'b1;
      acc_nxt  = (req.op == tsp_pkg::OP_MUL && !req.clr) ? acc_r : '0;
      cnt_nxt  = (req.op == tsp_pkg::OP_DIV) ? CW'(tsp_pkg::DIV_STEPS)
                                             : CW'(tsp_pkg::SQRT_STEPS);
    end else if (busy_r) begin
      case (op_r)
        tsp_pkg::OP_MUL: begin
          if (b_r == '0) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else begin
            if (b_r[0]) acc_nxt = acc_r + num_r;
            num_nxt = num_r << 1;
            b_nxt   = b_r >> 1;
          end
        end
        tsp_pkg::OP_DIV, tsp_pkg::OP_SQRT: begin
          if (op_r == tsp_pkg::OP_DIV) begin
            sh      = {rem_r[RW-2:0], num_r[PW-1]};
            sub     = {{(RW-BW){1'b0}}, b_r};
            num_nxt = num_r << 1;
          end else begin
            sh      = {rem_r[RW-3:0], num_r[PW-1:PW-2]};
            sub     = {acc_r[RW-3:0], 2'b01};
            num_nxt = num_r << 2;
          end
          ge      = (sh >= sub);
          dif     = sh - sub;
          rem_nxt = ge ? dif : sh;
          acc_nxt = {acc_r[PW-2:0], ge};
          cnt_nxt = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    num_r <= num_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res       = acc_r;

endmodule

@@ hdl/trapezoid_segment_planner.sv @@
// -----------------------------------------------------------------------------
// trapezoid_segment_planner: trapezoidal speed profile for multi-axis moves
// Plans accel, cruise and decel transitions with split points, or a single one.
// -----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------------
//  in_     | in  | in_valid / in_ready  | cmd, pos_a..pos_d, speed_in
//  out_    | out | out_valid / out_ready| kind, out_a..out_d, speeds, accel, last
//  cfg_    | in  | cfg_valid / cfg_ready| index, data (start speed, accel rate)
//
//  A speed request is taken in the idle state. A point request runs the shared
//  unit: multiplies (shorter for small multipliers), the square root and the
//  divides, in turn; a full three-ramp move takes the longest, as the single
//  iterative unit serves them all.
//  Results leave one per cycle through the output register; a stalled output
//  holds the sequencer in the emit state. No clearing pass after reset.
//
module trapezoid_segment_planner #(
  parameter int AXES = tsp_pkg::AXES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic signed [47:0] in_pos_a,
  input  logic signed [47:0] in_pos_b,
  input  logic signed [47:0] in_pos_c,
  input  logic signed [47:0] in_pos_d,
  input  logic [46:0]        in_speed_in,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic signed [47:0] out_a,
  output logic signed [47:0] out_b,
  output logic signed [47:0] out_c,
  output logic signed [47:0] out_d,
  output logic [46:0]        out_entry_speed,
  output logic signed [47:0] out_ramp_accel,
  output logic [46:0]        out_top_speed,
  output logic               out_last,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [46:0]        cfg_data
);

`include "trapezoid_segment_planner_defines.svh"

  localparam int PW  = tsp_pkg::PW;
  localparam int BW  = tsp_pkg::BW;
  localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  tsp_pkg::state_t   state_r, state_nxt;
  tsp_pkg::plan_t    plan_r, plan_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic [AXW-1:0]    axis_r, axis_nxt;
  logic              started_r, started_nxt;
  logic [46:0]       start_r, accel_r, want_r, want_nxt;
  logic signed [47:0] tgt_r [AXES];
  logic signed [47:0] tgt_nxt [AXES];
  logic signed [47:0] prev_r [AXES];
  logic signed [47:0] prev_nxt [AXES];
  logic [47:0]       off_r [AXES];
  logic [47:0]       off_nxt [AXES];
  logic [49:0]       dist_r, dist_nxt;
  logic [48:0]       ramp_r, ramp_nxt;

  // output register
  logic               ov_r, ov_nxt;
  logic               okind_r, okind_nxt;
  logic signed [47:0] opt_r [4];
  logic signed [47:0] opt_nxt [4];
  logic [46:0]        oentry_r, oentry_nxt;
  logic signed [47:0] oacc_r, oacc_nxt;
  logic [46:0]        otop_r, otop_nxt;
  logic               olast_r, olast_nxt;

  // shared unit
  tsp_pkg::alu_req_t  alu_req;
  tsp_pkg::alu_stat_t alu_stat;
  logic [PW-1:0]      alu_opa, alu_res;
  logic [BW-1:0]      alu_opb;

  tsp_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (alu_opa),
    .opb   (alu_opb),
    .stat  (alu_stat),
    .res   (alu_res)
  );

  // ---------------------------------------------------------------------------
  // Per-axis helpers
  // ---------------------------------------------------------------------------
  logic signed [47:0] pos_in [4];
  logic signed [48:0] diff;
  logic [47:0]        mag;
  logic               same;
  logic [47:0]        w_minus_s;
  logic [47:0]        w_plus_s;
  logic signed [47:0] tgt4 [4];
  logic signed [47:0] sp1 [4];
  logic signed [47:0] sp2 [4];
  logic signed [47:0] acc_pos, acc_neg;

  assign pos_in[0] = in_pos_a;
  assign pos_in[1] = in_pos_b;
  assign pos_in[2] = in_pos_c;
  assign pos_in[3] = in_pos_d;

  // move magnitude on the axis the sequencer is working on
  assign diff = {tgt_r[axis_r][47], tgt_r[axis_r]} - {prev_r[axis_r][47], prev_r[axis_r]};
  assign mag  = diff[48] ? 48'(-diff) : diff[47:0];

  assign w_minus_s = {1'b0, want_r} - {1'b0, start_r};
  assign w_plus_s  = {1'b0, want_r} + {1'b0, start_r};
  assign acc_pos   = {1'b0, accel_r};
  assign acc_neg   = -acc_pos;

  always_comb begin
    same = 1'b1;
    for (int k = 0; k < AXES; k++) begin
      if (pos_in[k] != prev_r[k]) same = 1'b0;
    end
  end

  // target and split points; unused axes read as zero
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tgt4[k] = '0;
      sp1[k]  = '0;
      sp2[k]  = '0;
    end
    for (int k = 0; k < AXES; k++) begin
      tgt4[k] = tgt_r[k];
      if (tgt_r[k] < prev_r[k]) begin
        sp1[k] = prev_r[k] - $signed(off_r[k]);
        sp2[k] = tgt_r[k] + $signed(off_r[k]);
      end else begin
        sp1[k] = prev_r[k] + $signed(off_r[k]);
        sp2[k] = tgt_r[k] - $signed(off_r[k]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result selection: plan and result index pick the fields
  // ---------------------------------------------------------------------------
  logic               r_kind;
  logic signed [47:0] r_pt [4];
  logic [46:0]        r_entry, r_top;
  logic signed [47:0] r_acc;
  logic [2:0]         r_cnt;
  logic               r_last;

  always_comb begin
    r_kind  = 1'b0;
    r_pt    = tgt4;
    r_entry = '0;
    r_acc   = '0;
    r_top   = '0;
    r_cnt   = 3'd2;
    case (plan_r)
      tsp_pkg::PLAN_ECHO: r_cnt = 3'd1;
      tsp_pkg::PLAN_CONST, tsp_pkg::PLAN_LIMIT: begin
        if (idx_r == 3'd0) begin
          r_kind  = 1'b1;
          r_pt    = '{default: '0};
          r_entry = (plan_r == tsp_pkg::PLAN_CONST) ? want_r : start_r;
          r_top   = want_r;
        end
      end
      tsp_pkg::PLAN_FULL: begin
        r_cnt = 3'd6;
        case (idx_r)
          3'd0: begin
            r_kind  = 1'b1;
            r_pt    = '{default: '0};
            r_entry = start_r;
            r_acc   = acc_pos;
            r_top   = want_r;
          end
          3'd1: r_pt = sp1;
          3'd2: begin
            r_kind  = 1'b1;
            r_pt    = '{default: '0};
            r_entry = want_r;
            r_top   = want_r;
          end
          3'd3: r_pt = sp2;
          3'd4: begin
            r_kind  = 1'b1;
            r_pt    = '{default: '0};
            r_entry = want_r;
            r_acc   = acc_neg;
            r_top   = want_r;
          end
          default: r_pt = tgt4;
        endcase
      end
      default: r_cnt = 3'd1;
    endcase
    r_last = (idx_r == r_cnt - 3'd1);
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    plan_nxt    = plan_r;
    idx_nxt     = idx_r;
    axis_nxt    = axis_r;
    started_nxt = started_r;
    want_nxt    = want_r;
    tgt_nxt     = tgt_r;
    prev_nxt    = prev_r;
    off_nxt     = off_r;
    dist_nxt    = dist_r;
    ramp_nxt    = ramp_r;
    ov_nxt      = ov_r & ~out_ready;
    okind_nxt   = okind_r;
    opt_nxt     = opt_r;
    oentry_nxt  = oentry_r;
    oacc_nxt    = oacc_r;
    otop_nxt    = otop_r;
    olast_nxt   = olast_r;
    alu_req     = '{go: 1'b0, op: tsp_pkg::OP_MUL, clr: 1'b1};
    alu_opa     = '0;
    alu_opb     = '0;
    in_ready    = 1'b0;

    case (state_r)
      tsp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_cmd) begin
            want_nxt = in_speed_in;
          end else begin
            for (int k = 0; k < AXES; k++) tgt_nxt[k] = pos_in[k];
            idx_nxt  = 3'd0;
            axis_nxt = '0;
            if (!started_r) begin
              plan_nxt  = tsp_pkg::PLAN_ECHO;
              state_nxt = tsp_pkg::ST_EMIT;
            end else if (same) begin
              state_nxt = tsp_pkg::ST_IDLE;   // repeated point: drop it
            end else if (want_r <= start_r) begin
              plan_nxt  = tsp_pkg::PLAN_CONST;
              state_nxt = tsp_pkg::ST_EMIT;
            end else begin
              state_nxt = tsp_pkg::ST_SUMSQ;
            end
          end
        end
      end

      // accumulate squared axis deltas in the unit's accumulator
      tsp_pkg::ST_SUMSQ: begin
        alu_req   = '{go: 1'b1, op: tsp_pkg::OP_MUL, clr: (axis_r == '0)};
        alu_opa   = PW'(mag);
        alu_opb   = BW'(mag);
        state_nxt = tsp_pkg::ST_SUMSQ_RUN;
      end
      tsp_pkg::ST_SUMSQ_RUN: begin
        if (alu_stat.done) begin
          if (axis_r == AXW'(AXES - 1)) begin
            state_nxt = tsp_pkg::ST_ROOT;
          end else begin
            axis_nxt  = axis_r + AXW'(1);
            state_nxt = tsp_pkg::ST_SUMSQ;
          end
        end
      end

      tsp_pkg::ST_ROOT: begin
        alu_req   = '{go: 1'b1, op: tsp_pkg::OP_SQRT, clr: 1'b1};
        alu_opa   = alu_res;
        state_nxt = tsp_pkg::ST_ROOT_RUN;
      end
      tsp_pkg::ST_ROOT_RUN: begin
        if (alu_stat.done) begin
          dist_nxt = alu_res[49:0];
          if (accel_r == '0) begin
            plan_nxt  = tsp_pkg::PLAN_LIMIT;
            state_nxt = tsp_pkg::ST_EMIT;
          end else begin
            state_nxt = tsp_pkg::ST_LEN;
          end
        end
      end

      // W*W - S0*S0 as (W - S0) * (W + S0)
      tsp_pkg::ST_LEN: begin
        alu_req   = '{go: 1'b1, op: tsp_pkg::OP_MUL, clr: 1'b1};
        alu_opa   = PW'(w_minus_s);
        alu_opb   = BW'(w_plus_s);
        state_nxt = tsp_pkg::ST_LEN_RUN;
      end
      tsp_pkg::ST_LEN_RUN: begin
        if (alu_stat.done) state_nxt = tsp_pkg::ST_RAMP;
      end

      tsp_pkg::ST_RAMP: begin
        alu_req   = '{go: 1'b1, op: tsp_pkg::OP_DIV, clr: 1'b1};
        alu_opa   = alu_res;
        alu_opb   = {2'b00, accel_r, 1'b0};
        state_nxt = tsp_pkg::ST_RAMP_RUN;
      end
      tsp_pkg::ST_RAMP_RUN: begin
        if (alu_stat.done) begin
          // ramps meet or overlap: single transition
          if (alu_res[PW-1:49] != '0 || {alu_res[48:0], 1'b0} >= dist_r) begin
            plan_nxt  = tsp_pkg::PLAN_LIMIT;
            state_nxt = tsp_pkg::ST_EMIT;
          end else begin
            ramp_nxt  = alu_res[48:0];
            axis_nxt  = '0;
            state_nxt = tsp_pkg::ST_OFFMUL;
          end
        end
      end

      // split offset = |d| * ramp / dist per axis
      tsp_pkg::ST_OFFMUL: begin
        alu_req   = '{go: 1'b1, op: tsp_pkg::OP_MUL, clr: 1'b1};
        alu_opa   = PW'(mag);
        alu_opb   = BW'(ramp_r);
        state_nxt = tsp_pkg::ST_OFFMUL_RUN;
      end
      tsp_pkg::ST_OFFMUL_RUN: begin
        if (alu_stat.done) state_nxt = tsp_pkg::ST_OFFDIV;
      end
      tsp_pkg::ST_OFFDIV: begin
        alu_req   = '{go: 1'b1, op: tsp_pkg::OP_DIV, clr: 1'b1};
        alu_opa   = alu_res;
        alu_opb   = dist_r;
        state_nxt = tsp_pkg::ST_OFFDIV_RUN;
      end
      tsp_pkg::ST_OFFDIV_RUN: begin
        if (alu_stat.done) begin
          off_nxt[axis_r] = alu_res[47:0];
          if (axis_r == AXW'(AXES - 1)) begin
            plan_nxt  = tsp_pkg::PLAN_FULL;
            idx_nxt   = 3'd0;
            state_nxt = tsp_pkg::ST_EMIT;
          end else begin
            axis_nxt  = axis_r + AXW'(1);
            state_nxt = tsp_pkg::ST_OFFMUL;
          end
        end
      end

      // advance one result whenever the output register is free
      tsp_pkg::ST_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt     = 1'b1;
          okind_nxt  = r_kind;
          opt_nxt    = r_pt;
          oentry_nxt = r_entry;
          oacc_nxt   = r_acc;
          otop_nxt   = r_top;
          olast_nxt  = r_last;
          idx_nxt    = idx_r + 3'd1;
          if (r_last) begin
            prev_nxt    = tgt_r;
            started_nxt = 1'b1;
            state_nxt   = tsp_pkg::ST_IDLE;
          end
        end
      end

      default: state_nxt = tsp_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tsp_pkg::ST_IDLE;
      started_r <= 1'b0;
      ov_r      <= 1'b0;
      want_r    <= tsp_pkg::WANT_RST;
      start_r   <= tsp_pkg::START_RST;
      accel_r   <= tsp_pkg::ACCEL_RST;
      for (int k = 0; k < AXES; k++) prev_r[k] <= '0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
      ov_r      <= ov_nxt;
      want_r    <= want_nxt;
      prev_r    <= prev_nxt;
      if (cfg_valid) begin
        if (cfg_index == tsp_pkg::CFG_START) start_r <= cfg_data;
        if (cfg_index == tsp_pkg::CFG_ACCEL) accel_r <= cfg_data;
      end
    end
    plan_r   <= plan_nxt;
    idx_r    <= idx_nxt;
    axis_r   <= axis_nxt;
    tgt_r    <= tgt_nxt;
    off_r    <= off_nxt;
    dist_r   <= dist_nxt;
    ramp_r   <= ramp_nxt;
    okind_r  <= okind_nxt;
    opt_r    <= opt_nxt;
    oentry_r <= oentry_nxt;
    oacc_r   <= oacc_nxt;
    otop_r   <= otop_nxt;
    olast_r  <= olast_nxt;
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = ov_r;
  assign out_kind        = okind_r;
  assign out_a           = opt_r[0];
  assign out_b           = opt_r[1];
  assign out_c           = opt_r[2];
  assign out_d           = opt_r[3];
  assign out_entry_speed = oentry_r;
  assign out_ramp_accel  = oacc_r;
  assign out_top_speed   = otop_r;
  assign out_last        = olast_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TSP_ASSERT(a_no_go_busy, alu_req.go |-> !alu_stat.busy, "unit started while busy")
  `TSP_ASSERT(a_rise_emit, $rose(ov_r) |-> $past(state_r) == tsp_pkg::ST_EMIT,
              "result raised outside emit")
  `TSP_ASSERT(a_burst_cont, (ov_r && out_ready && !olast_r) |=> ov_r,
              "gap inside result burst")

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for trapezoid_segment_planner
// Feeds speed and point requests through a valid/ready driver, predicts the
// motion plan (transitions and split points) per request and compares every
// result field against the oldest prediction. Both register settings change
// between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int WDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 1200;

  typedef struct packed {
    logic               cmd;
    logic signed [47:0] pa, pb, pc, pd;
    logic [46:0]        spd;
  } move_req_t;

  typedef struct packed {
    logic               kind;
    logic signed [47:0] a, b, c, d;
    logic [46:0]        entry;
    logic signed [47:0] accel;
    logic [46:0]        top;
    logic               last;
  } plan_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready, in_cmd = 1'b0;
  logic signed [47:0] in_pos_a = '0, in_pos_b = '0, in_pos_c = '0, in_pos_d = '0;
  logic [46:0] in_speed_in = '0;
  logic out_valid, out_ready = 1'b0, out_kind, out_last;
  logic signed [47:0] out_a, out_b, out_c, out_d, out_ramp_accel;
  logic [46:0] out_entry_speed, out_top_speed;
  logic cfg_valid = 1'b0, cfg_ready, cfg_index = tsp_pkg::CFG_START;
  logic [46:0] cfg_data = '0;

  trapezoid_segment_planner uut (.*);

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  move_req_t pending_reqs[$];
  plan_res_t expected_plan[$];

  // predictor state
  logic [46:0] pr_start = tsp_pkg::START_RST, pr_accel = tsp_pkg::ACCEL_RST;
  logic [46:0] pr_wanted = tsp_pkg::WANT_RST;
  logic signed [47:0] pr_prev[4] = '{default: '0};
  bit pr_started = 0;

  int errors = 0, n_sent = 0, n_results = 0, n_full = 0, n_limit = 0, n_const = 0;
  bit calm = 0;         // no random idling
  bit hold_off = 0;     // long receiver stall
  int idle_cnt = 0;

  function automatic logic [127:0] isqrt128(logic [127:0] s);
    logic [127:0] lo, hi, mid;
    lo = 0;
    hi = 128'd1 << 51;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (mid * mid <= s) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic void push_res(logic kind, logic signed [47:0] p[4],
                                   logic [46:0] entry, logic signed [47:0] acc,
                                   logic [46:0] top);
    plan_res_t r;
    r.kind = kind;
    r.a = p[0]; r.b = p[1]; r.c = p[2]; r.d = p[3];
    r.entry = entry; r.accel = acc; r.top = top; r.last = 1'b0;
    expected_plan = {expected_plan, r};
  endfunction

  // predict the plan of one accepted request
  function automatic void plan_move(move_req_t q);
    logic signed [47:0] tgt[4], zp[4], p1[4], p2[4];
    logic [127:0] sum, ramp, w2, s2, seg_len, off;
    logic [63:0] mag[4];
    bit same, limited;
    int n0;
    zp = '{default: '0};
    n0 = expected_plan.size();
    if (!q.cmd) begin
      pr_wanted = q.spd;
      return;
    end
    tgt = '{q.pa, q.pb, q.pc, q.pd};
    same = 1;
    for (int i = 0; i < 4; i++) if (tgt[i] != pr_prev[i]) same = 0;
    if (!pr_started) push_res(1'b0, tgt, '0, '0, '0);
    else if (!same) begin
      if (pr_wanted <= pr_start) begin
        n_const++;
        push_res(1'b1, zp, pr_wanted, '0, pr_wanted);
        push_res(1'b0, tgt, '0, '0, '0);
      end else begin
        sum = 0;
        for (int i = 0; i < 4; i++) begin
          mag[i] = (tgt[i] < pr_prev[i]) ? 64'(pr_prev[i]) - 64'(tgt[i])
                                          : 64'(tgt[i]) - 64'(pr_prev[i]);
          sum += 128'(mag[i]) * 128'(mag[i]);
        end
        seg_len = isqrt128(sum);
        ramp = 0;
        if (pr_accel == 0) limited = 1;
        else begin
          w2 = 128'(pr_wanted) * 128'(pr_wanted);
          s2 = 128'(pr_start) * 128'(pr_start);
          ramp = (w2 - s2) / (128'(pr_accel) * 2);
          limited = ramp >= (128'd1 << 62) || 2 * ramp >= seg_len;
        end
        if (limited) begin
          n_limit++;
          push_res(1'b1, zp, pr_start, '0, pr_wanted);
          push_res(1'b0, tgt, '0, '0, '0);
        end else begin
          n_full++;
          for (int i = 0; i < 4; i++) begin
            off = (128'(mag[i]) * ramp) / seg_len;
            if (tgt[i] < pr_prev[i]) begin
              p1[i] = pr_prev[i] - 48'(off);
              p2[i] = tgt[i] + 48'(off);
            end else begin
              p1[i] = pr_prev[i] + 48'(off);
              p2[i] = tgt[i] - 48'(off);
            end
          end
          push_res(1'b1, zp, pr_start, 48'(pr_accel), pr_wanted);
          push_res(1'b0, p1, '0, '0, '0);
          push_res(1'b1, zp, pr_wanted, '0, pr_wanted);
          push_res(1'b0, p2, '0, '0, '0);
          push_res(1'b1, zp, pr_wanted, -48'(pr_accel), pr_wanted);
          push_res(1'b0, tgt, '0, '0, '0);
        end
      end
    end
    pr_started = 1;
    pr_prev = tgt;
    if (expected_plan.size() > n0) expected_plan[$].last = 1'b1;
  endfunction

  // driver: hold the request until accepted, idle at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        plan_move('{in_cmd, in_pos_a, in_pos_b, in_pos_c, in_pos_d, in_speed_in});
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
          move_req_t q;
          q = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_cmd <= q.cmd;
          in_pos_a <= q.pa; in_pos_b <= q.pb; in_pos_c <= q.pc; in_pos_d <= q.pd;
          in_speed_in <= q.spd;
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        plan_res_t act, exp_r;
        act = '{out_kind, out_a, out_b, out_c, out_d, out_entry_speed,
                out_ramp_accel, out_top_speed, out_last};
        n_results++;
        if (expected_plan.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, actual %h", $time, act);
        end else begin
          exp_r = expected_plan.pop_front();
          if (act !== exp_r) begin
            errors++;
            $display("%0t mismatch: expected %h, actual %h", $time, exp_r, act);
          end
        end
      end
      out_ready <= !hold_off && (calm || $urandom_range(99) >= 21);
    end
  end

  // watchdog: count cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || pending_reqs.size() == 0 && expected_plan.size() == 0)
      idle_cnt <= 0;
    else if (++idle_cnt >= WDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic logic signed [47:0] rand_pos();
    case ($urandom_range(5))
      0: return 48'sh7FFF_FFFF_FFFF;
      1: return 48'sh8000_0000_0000;
      2: return 48'({$urandom, $urandom} >> 16);
      default: return 48'($signed($urandom_range(2000000) - 1000000)) <<< 8;
    endcase
  endfunction

  task automatic add_speed(logic [46:0] s);
    move_req_t q;
    q = '{1'b0, 48'($urandom), 48'($urandom), 48'($urandom), 48'($urandom), s};
    pending_reqs = {pending_reqs, q};
  endtask

  task automatic add_point(logic signed [47:0] a, b, c, d);
    move_req_t q;
    q = '{1'b1, a, b, c, d, 47'($urandom)};
    pending_reqs = {pending_reqs, q};
  endtask

  // write one register while the block is idle
  task automatic write_reg(logic idx, logic [46:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == tsp_pkg::CFG_START) pr_start = val; else pr_accel = val;
    cfg_valid <= 1'b0;
  endtask

  // drain pending requests and predictions, then let the unit settle
  task automatic settle();
    wait (pending_reqs.size() == 0 && !in_valid && expected_plan.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random phase: mostly real moves, a mix of speeds and repeated points
  task automatic random_moves(int count);
    logic signed [47:0] a, b, c, d;
    a = 0; b = 0; c = 0; d = 0;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0, 1: add_speed($urandom_range(3) == 0 ? 47'({$urandom, $urandom})
                                                : 47'($urandom_range(3000000)) << 8);
        2: add_point(a, b, c, d);
        default: begin
          a = rand_pos(); b = rand_pos(); c = rand_pos(); d = rand_pos();
          add_point(a, b, c, d);
        end
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: echo, repeat, extremes, each plan shape
    add_point(0, 0, 0, 0);
    add_point(0, 0, 0, 0);
    add_point(48'sh7FFF_FFFF_FFFF, 48'sh8000_0000_0000, 48'sh7FFF_FFFF_FFFF,
              48'sh8000_0000_0000);
    add_speed(47'd100 << 16);                         // short ramp: full plan
    add_point(0, 0, 0, 0);
    add_point(48'sd1 <<< 16, 0, 0, 0);                // tiny move: ramp-limited
    add_speed(47'd1 << 16);                           // below start: constant
    add_point(48'sd2 <<< 16, -48'sd5 <<< 16, 0, 0);
    add_speed(47'h7FFF_FFFF_FFFF);
    add_point(48'sh8000_0000_0000, 48'sh7FFF_FFFF_FFFF, 48'sh8000_0000_0000,
              48'sh7FFF_FFFF_FFFF);
    add_speed(47'd0);
    add_point(1, 2, 3, 4);
    settle();

    // extremes of the registers
    write_reg(tsp_pkg::CFG_START, 47'd0);
    write_reg(tsp_pkg::CFG_ACCEL, 47'h7FFF_FFFF_FFFF);
    add_speed(47'd50 << 16);
    add_point(-48'sd100 <<< 16, 48'sd30 <<< 16, 0, 48'sd7);
    add_point(48'sh7FFF_FFFF_FFFF, 0, 0, 0);
    settle();
    write_reg(tsp_pkg::CFG_ACCEL, 47'd0);             // zero rate: limited, constant once the speed drops to start
    add_point(5, 6, 7, 8);
    add_speed(47'd0);
    add_point(9, 6, 7, 8);
    settle();
    write_reg(tsp_pkg::CFG_START, 47'h7FFF_FFFF_FFFF);
    write_reg(tsp_pkg::CFG_ACCEL, 47'd1);
    add_speed(47'h7FFF_FFFF_FFFF);
    add_point(-5, 6, 7, 8);
    settle();

    // random with default-like settings, long stretch without idling
    write_reg(tsp_pkg::CFG_START, 47'd327680);
    write_reg(tsp_pkg::CFG_ACCEL, 47'd6553600 << 8);
    calm = 1;
    random_moves(40);
    settle();
    calm = 0;
    random_moves(40);

    // receiver stalls while the sender keeps offering
    hold_off = 1;
    repeat (3000) @(posedge clk);
    hold_off = 0;
    settle();

    write_reg(tsp_pkg::CFG_START, 47'($urandom) << 4);
    write_reg(tsp_pkg::CFG_ACCEL, 47'({$urandom, $urandom}));
    random_moves(40);
    settle();

    $display("tb: %0d requests, %0d results; plans: %0d full, %0d limited, %0d const",
             n_sent, n_results, n_full, n_limit, n_const);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
